/* hdl/multi_channel_timer_bank_top_assert.svh */
// Assertion macros for the checker file of the timer bank.
`ifndef MULTI_CHANNEL_TIMER_BANK_TOP_ASSERT_SVH
`define MULTI_CHANNEL_TIMER_BANK_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MCTB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MCTB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/mctb_pkg.sv */
// ----------------------------------------------------------------------------
// mctb_pkg
// Types and fixed constants of the multi-channel timer bank.
// ----------------------------------------------------------------------------
package mctb_pkg;

  localparam int ID_W      = 8;
  localparam int MSG_W     = 16;
  localparam int CTX_W     = 32;
  localparam int DEST_W    = 8;
  localparam int MS_W      = 24;
  localparam int TICKS_W   = 21;
  localparam int PERIOD_W  = 25;
  localparam int MAX_OUT   = 16;
  localparam int CNT_W     = $clog2(MAX_OUT + 1);

  localparam logic [TICKS_W-1:0]  TICKS_MAX  = '1;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;

  typedef enum logic [1:0] {
    ACT_SET   = 2'd0,
    ACT_KILL  = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_QUERY = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_DONE   = 2'd0,
    KIND_BAD_ID = 2'd1,
    KIND_EXPIRY = 2'd2,
    KIND_QUERY  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SET_CALC,
    S_SET_WR,
    S_KILL,
    S_BAD,
    S_QRD,
    S_QMUL,
    S_QOUT,
    S_TICK_RD,
    S_TICK_LAST,
    S_TICK_END
  } state_t;

  typedef struct packed {
    logic                periodic;
    logic [TICKS_W-1:0]  reload;
    logic [TICKS_W-1:0]  remaining;
    logic [MSG_W-1:0]    msg;
    logic [CTX_W-1:0]    ctx;
    logic [DEST_W-1:0]   dest;
  } entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [ID_W-1:0]  rd_addr;
    logic             wr_en;
    logic [ID_W-1:0]  wr_addr;
    entry_t           wr_data;
  } mem_req_t;

endpackage

/* hdl/mctb_store.sv */
// ----------------------------------------------------------------------------
// mctb_store
// Timer entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mctb_store #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  mctb_pkg::mem_req_t  req,
  output mctb_pkg::entry_t    rd_data
);
  import mctb_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr[AW-1:0]];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/mctb_ticks.sv */
// ----------------------------------------------------------------------------
// mctb_ticks
// Milliseconds to ticks, rounded up and saturated; one registered multiply
// by the reciprocal of the tick length, result valid in the cycle after ms.
// ----------------------------------------------------------------------------
module mctb_ticks #(
  parameter int TICK_MS = 10
) (
  input  logic                         clk,
  input  logic [mctb_pkg::MS_W-1:0]    ms,
  output logic [mctb_pkg::TICKS_W-1:0] ticks
);
  import mctb_pkg::*;

  localparam int NUM_W  = MS_W + 1;
  localparam int SHIFT  = NUM_W + $clog2(TICK_MS);
  localparam int MAG_W  = NUM_W + 2;
  localparam int PROD_W = NUM_W + MAG_W;
  localparam logic [63:0] MAGIC_FULL =
    ((64'd1 << SHIFT) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS);
  localparam logic [MAG_W-1:0] MAGIC = MAG_W'(MAGIC_FULL);

  logic [NUM_W-1:0]  num;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] quot;

  // round up: floor((ms + TICK_MS - 1) / TICK_MS)
  assign num = NUM_W'(ms) + NUM_W'(TICK_MS - 1);

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(num) * PROD_W'(MAGIC);
  end

  assign quot  = prod_r >> SHIFT;
  assign ticks = (quot > PROD_W'(TICKS_MAX)) ? TICKS_MAX : quot[TICKS_W-1:0];

endmodule

/* hdl/multi_channel_timer_bank_top.sv */
// ----------------------------------------------------------------------------
// multi_channel_timer_bank_top
// Bank of one-shot and looping timers kept in a single entry memory.
// ----------------------------------------------------------------------------
// One item is taken at a time: busy stays high from the accept until the
// last result has been issued. A kill or a rejected timer id is answered
// from S_KILL or S_BAD; a set waits in S_SET_CALC for the registered
// multiply that rounds ms to ticks, then writes in S_SET_WR; a query reads
// in S_QRD, multiplies by the tick length into a register in S_QMUL and
// answers in S_QOUT. A tick walks the entry memory one timer per cycle,
// reading one entry while writing back the one before. Each result shows on
// the out_ ports for exactly one cycle with out_valid high and must be taken
// then; out_last marks the final result of an item. A tick emits at most 16
// expiry results and one done result when no timer fires.
// ----------------------------------------------------------------------------
module multi_channel_timer_bank_top #(
  parameter int NUM_TIMERS = 16,
  parameter int TICK_MS    = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_timer_id,
  input  logic [15:0] in_msg_id,
  input  logic [31:0] in_context_req,
  input  logic [7:0]  in_destination,
  input  logic [23:0] in_interval_ms,
  input  logic        in_looping,
  output logic        busy,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_which_timer,
  output logic [15:0] out_expired_msg,
  output logic [31:0] out_expired_context,
  output logic [7:0]  out_expired_destination,
  output logic [24:0] out_period_ms,
  output logic        out_active,
  output logic        out_last
);
  import mctb_pkg::*;

  localparam int IDX_W   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int QPROD_W = TICKS_W + $clog2(TICK_MS + 1);

  state_t                 state_r, state_nxt;
  logic [ID_W-1:0]        id_r, id_nxt;
  logic [MSG_W-1:0]       msg_r, msg_nxt;
  logic [CTX_W-1:0]       ctx_r, ctx_nxt;
  logic [DEST_W-1:0]      dest_r, dest_nxt;
  logic [MS_W-1:0]        ms_r, ms_nxt;
  logic                   loop_r, loop_nxt;
  logic [IDX_W-1:0]       walk_r, walk_nxt;
  logic                   chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]       chk_idx_r, chk_idx_nxt;
  logic [NUM_TIMERS-1:0]  enabled_r, enabled_nxt;
  logic [CNT_W-1:0]       exp_cnt_r, exp_cnt_nxt;
  logic                   pend_vld_r, pend_vld_nxt;
  logic [IDX_W-1:0]       pend_idx_r, pend_idx_nxt;
  logic [MSG_W-1:0]       pend_msg_r, pend_msg_nxt;
  logic [CTX_W-1:0]       pend_ctx_r, pend_ctx_nxt;
  logic [DEST_W-1:0]      pend_dest_r, pend_dest_nxt;
  logic [QPROD_W-1:0]     qprod_r, qprod_nxt;

  logic                   out_valid_r, out_valid_nxt;
  kind_t                  out_kind_r, out_kind_nxt;
  logic [ID_W-1:0]        out_which_r, out_which_nxt;
  logic [MSG_W-1:0]       out_msg_r, out_msg_nxt;
  logic [CTX_W-1:0]       out_ctx_r, out_ctx_nxt;
  logic [DEST_W-1:0]      out_dest_r, out_dest_nxt;
  logic [PERIOD_W-1:0]    out_period_r, out_period_nxt;
  logic                   out_active_r, out_active_nxt;
  logic                   out_last_r, out_last_nxt;

  mem_req_t               mreq;
  entry_t                 rd_data;
  logic [TICKS_W-1:0]     set_ticks;
  logic                   id_bad;
  logic [TICKS_W-1:0]     rem_dec;
  logic                   chk_en;
  logic                   fire;

  mctb_store #(.DEPTH(NUM_TIMERS)) u_store (
    .clk     (clk),
    .req     (mreq),
    .rd_data (rd_data)
  );

  mctb_ticks #(.TICK_MS(TICK_MS)) u_ticks (
    .clk   (clk),
    .ms    (ms_r),
    .ticks (set_ticks)
  );

  assign id_bad  = {1'b0, in_timer_id} >= 9'(NUM_TIMERS);
  assign chk_en  = enabled_r[chk_idx_r];
  assign rem_dec = (rd_data.remaining != '0) ? rd_data.remaining - 1'b1 : '0;
  assign fire    = chk_vld_r && chk_en && (rem_dec == '0);

  always_comb begin
    state_nxt      = state_r;
    id_nxt         = id_r;
    msg_nxt        = msg_r;
    ctx_nxt        = ctx_r;
    dest_nxt       = dest_r;
    ms_nxt         = ms_r;
    loop_nxt       = loop_r;
    walk_nxt       = walk_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    enabled_nxt    = enabled_r;
    exp_cnt_nxt    = exp_cnt_r;
    pend_vld_nxt   = pend_vld_r;
    pend_idx_nxt   = pend_idx_r;
    pend_msg_nxt   = pend_msg_r;
    pend_ctx_nxt   = pend_ctx_r;
    pend_dest_nxt  = pend_dest_r;
    qprod_nxt      = qprod_r;

    out_valid_nxt  = 1'b0;
    out_kind_nxt   = out_kind_r;
    out_which_nxt  = out_which_r;
    out_msg_nxt    = out_msg_r;
    out_ctx_nxt    = out_ctx_r;
    out_dest_nxt   = out_dest_r;
    out_period_nxt = out_period_r;
    out_active_nxt = out_active_r;
    out_last_nxt   = out_last_r;

    mreq           = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          id_nxt       = in_timer_id;
          msg_nxt      = in_msg_id;
          ctx_nxt      = in_context_req;
          dest_nxt     = in_destination;
          ms_nxt       = in_interval_ms;
          loop_nxt     = in_looping;
          walk_nxt     = '0;
          exp_cnt_nxt  = '0;
          pend_vld_nxt = 1'b0;
          case (action_t'(in_action))
            ACT_TICK:  state_nxt = S_TICK_RD;
            ACT_SET:   state_nxt = id_bad ? S_BAD : S_SET_CALC;
            ACT_KILL:  state_nxt = id_bad ? S_BAD : S_KILL;
            ACT_QUERY: state_nxt = id_bad ? S_BAD : S_QRD;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end

      // wait for the rounded tick count from the registered multiply
      S_SET_CALC: state_nxt = S_SET_WR;

      S_SET_WR: begin
        mreq.wr_en                     = 1'b1;
        mreq.wr_addr                   = id_r;
        mreq.wr_data.periodic          = loop_r;
        mreq.wr_data.reload            = set_ticks;
        mreq.wr_data.remaining         = set_ticks;
        mreq.wr_data.msg               = msg_r;
        mreq.wr_data.ctx               = ctx_r;
        mreq.wr_data.dest              = dest_r;
        enabled_nxt[id_r[IDX_W-1:0]]   = 1'b1;
        out_valid_nxt  = 1'b1;
        out_kind_nxt   = KIND_DONE;
        out_which_nxt  = id_r;
        out_msg_nxt    = '0;
        out_ctx_nxt    = '0;
        out_dest_nxt   = '0;
        out_period_nxt = '0;
        out_active_nxt = 1'b0;
        out_last_nxt   = 1'b1;
        state_nxt      = S_IDLE;
      end

      S_KILL: begin
        enabled_nxt[id_r[IDX_W-1:0]] = 1'b0;
        out_valid_nxt  = 1'b1;
        out_kind_nxt   = KIND_DONE;
        out_which_nxt  = id_r;
        out_msg_nxt    = '0;
        out_ctx_nxt    = '0;
        out_dest_nxt   = '0;
        out_period_nxt = '0;
        out_active_nxt = 1'b0;
        out_last_nxt   = 1'b1;
        state_nxt      = S_IDLE;
      end

      S_BAD: begin
        out_valid_nxt  = 1'b1;
        out_kind_nxt   = KIND_BAD_ID;
        out_which_nxt  = id_r;
        out_msg_nxt    = '0;
        out_ctx_nxt    = '0;
        out_dest_nxt   = '0;
        out_period_nxt = '0;
        out_active_nxt = 1'b0;
        out_last_nxt   = 1'b1;
        state_nxt      = S_IDLE;
      end

      S_QRD: begin
        mreq.rd_en   = 1'b1;
        mreq.rd_addr = id_r;
        state_nxt    = S_QMUL;
      end

      S_QMUL: begin
        qprod_nxt = QPROD_W'(rd_data.reload) * QPROD_W'(TICK_MS);
        state_nxt = S_QOUT;
      end

      S_QOUT: begin
        out_valid_nxt  = 1'b1;
        out_kind_nxt   = KIND_QUERY;
        out_which_nxt  = id_r;
        out_msg_nxt    = '0;
        out_ctx_nxt    = '0;
        out_dest_nxt   = '0;
        out_period_nxt = (qprod_r > QPROD_W'(PERIOD_MAX)) ? PERIOD_MAX
                                                          : PERIOD_W'(qprod_r);
        out_active_nxt = enabled_r[id_r[IDX_W-1:0]];
        out_last_nxt   = 1'b1;
        state_nxt      = S_IDLE;
      end

      S_TICK_RD: begin
        mreq.rd_en   = 1'b1;
        mreq.rd_addr = ID_W'(walk_r);
        chk_vld_nxt  = 1'b1;
        chk_idx_nxt  = walk_r;
        if (walk_r == IDX_W'(NUM_TIMERS - 1)) begin
          state_nxt = S_TICK_LAST;
        end else begin
          walk_nxt = walk_r + 1'b1;
        end
      end

      // last entry is checked in this cycle
      S_TICK_LAST: state_nxt = S_TICK_END;

      S_TICK_END: begin
        out_valid_nxt  = 1'b1;
        out_period_nxt = '0;
        out_active_nxt = 1'b0;
        out_last_nxt   = 1'b1;
        if (pend_vld_r) begin
          out_kind_nxt  = KIND_EXPIRY;
          out_which_nxt = ID_W'(pend_idx_r);
          out_msg_nxt   = pend_msg_r;
          out_ctx_nxt   = pend_ctx_r;
          out_dest_nxt  = pend_dest_r;
        end else begin
          out_kind_nxt  = KIND_DONE;
          out_which_nxt = '0;
          out_msg_nxt   = '0;
          out_ctx_nxt   = '0;
          out_dest_nxt  = '0;
        end
        pend_vld_nxt = 1'b0;
        state_nxt    = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase

    // tick check stage: update the enabled entry read last cycle and write it back
    if (chk_vld_r && chk_en) begin
      mreq.wr_en             = 1'b1;
      mreq.wr_addr           = ID_W'(chk_idx_r);
      mreq.wr_data           = rd_data;
      mreq.wr_data.remaining = (fire && rd_data.periodic) ? rd_data.reload : rem_dec;
    end
    if (fire) begin
      if (!rd_data.periodic) begin
        enabled_nxt[chk_idx_r] = 1'b0;
      end
      if (exp_cnt_r < CNT_W'(MAX_OUT)) begin
        // hold the newest expiry until we know whether it is the last one
        if (pend_vld_r) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_EXPIRY;
          out_which_nxt  = ID_W'(pend_idx_r);
          out_msg_nxt    = pend_msg_r;
          out_ctx_nxt    = pend_ctx_r;
          out_dest_nxt   = pend_dest_r;
          out_period_nxt = '0;
          out_active_nxt = 1'b0;
          out_last_nxt   = 1'b0;
        end
        pend_vld_nxt  = 1'b1;
        pend_idx_nxt  = chk_idx_r;
        pend_msg_nxt  = rd_data.msg;
        pend_ctx_nxt  = rd_data.ctx;
        pend_dest_nxt = rd_data.dest;
        exp_cnt_nxt   = exp_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      chk_vld_r   <= 1'b0;
      enabled_r   <= '0;
      exp_cnt_r   <= '0;
      pend_vld_r  <= 1'b0;
      walk_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chk_vld_r   <= chk_vld_nxt;
      enabled_r   <= enabled_nxt;
      exp_cnt_r   <= exp_cnt_nxt;
      pend_vld_r  <= pend_vld_nxt;
      walk_r      <= walk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r         <= id_nxt;
    msg_r        <= msg_nxt;
    ctx_r        <= ctx_nxt;
    dest_r       <= dest_nxt;
    ms_r         <= ms_nxt;
    loop_r       <= loop_nxt;
    chk_idx_r    <= chk_idx_nxt;
    pend_idx_r   <= pend_idx_nxt;
    pend_msg_r   <= pend_msg_nxt;
    pend_ctx_r   <= pend_ctx_nxt;
    pend_dest_r  <= pend_dest_nxt;
    qprod_r      <= qprod_nxt;
    out_kind_r   <= out_kind_nxt;
    out_which_r  <= out_which_nxt;
    out_msg_r    <= out_msg_nxt;
    out_ctx_r    <= out_ctx_nxt;
    out_dest_r   <= out_dest_nxt;
    out_period_r <= out_period_nxt;
    out_active_r <= out_active_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign busy                    = (state_r != S_IDLE);
  assign out_valid               = out_valid_r;
  assign out_kind                = out_kind_r;
  assign out_which_timer         = out_which_r;
  assign out_expired_msg         = out_msg_r;
  assign out_expired_context     = out_ctx_r;
  assign out_expired_destination = out_dest_r;
  assign out_period_ms           = out_period_r;
  assign out_active              = out_active_r;
  assign out_last                = out_last_r;

endmodule

/* hdl/mctb_checker.sv */
// ----------------------------------------------------------------------------
// mctb_checker
// Port-level checks of the timer bank, bound to the top level.
// ----------------------------------------------------------------------------
`include "multi_channel_timer_bank_top_assert.svh"

module mctb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_kind,
  input logic [24:0] out_period_ms,
  input logic        out_active,
  input logic        out_last
);
  import mctb_pkg::*;

  // an accepted item makes the block busy in the next cycle
  `MCTB_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "item accepted without going busy")

  // only expiries can be followed by more results of the same item
  `MCTB_ASSERT_NOW(a_single_last, out_valid && out_kind != KIND_EXPIRY, out_last,
    "non-expiry result without last")

  // more results pending means the item is still in work
  `MCTB_ASSERT_NOW(a_more_busy, out_valid && !out_last, busy,
    "intermediate result while idle")

  // a new item cannot report in the cycle right after a final result
  `MCTB_ASSERT_NEXT(a_gap_after_last, out_valid && out_last, !out_valid,
    "result directly after last result")

  // query fields stay clear outside query answers
  `MCTB_ASSERT_NOW(a_query_fields, out_valid && out_kind != KIND_QUERY,
    !out_active && out_period_ms == '0, "query fields set outside query answer")

endmodule

bind multi_channel_timer_bank_top mctb_checker u_mctb_checker (.*);
